FILE: rtl/core/dpdq_pkg.sv
package dpdq_pkg;

    localparam int ID_W = 16;

    typedef enum logic [1:0] {
        CMD_ENQ_CRIT  = 2'd0,
        CMD_ENQ_OVF   = 2'd1,
        CMD_SELECT    = 2'd2,
        CMD_CLEAR_OVF = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_EMPTY = 3'd3,
        ST_BUSY  = 3'd4
    } status_t;

    // Request from the command decoder to one queue.
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    // Condition of one queue as seen by the decoder.
    typedef struct packed {
        logic            full;
        logic            empty;
        logic            dup;
        logic [ID_W-1:0] head;
    } q_stat_t;

endpackage

FILE: rtl/core/dual_priority_dedup_event_queue_unit.sv
// Dual priority deduplicating event queue.
//
// Input channel (in_valid/in_ready) carries one request: command, evt_id
// and poll_busy. Output channel (out_valid/out_ready) returns one result per
// request: status, event_valid, selected_id and critical_active.
//
// Each queue is a row of QUEUE_DEPTH cells with the head in cell 0. Every
// cell compares its entry with the incoming ID in parallel, and on a pop
// every cell but the tail takes its right neighbor's entry, so a request
// is decoded and applied against the live cell contents.
// The result is registered and appears in the cycle after acceptance.
// One request per cycle is accepted while the receiver takes each result.
//
// A stalled receiver holds the result in the output register; a new request
// is accepted in the same cycle the pending result is taken.
// Reset empties both queues, clears the critical-active flag and drops any
// pending result. Cell contents are not cleared.
module dual_priority_dedup_event_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                command,
    input  logic [dpdq_pkg::ID_W-1:0] evt_id,
    input  logic                      poll_busy,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                status,
    output logic                      event_valid,
    output logic [dpdq_pkg::ID_W-1:0] selected_id,
    output logic                      critical_active
);

    dpdq_pkg::q_ctrl_t crit_ctrl;
    dpdq_pkg::q_ctrl_t ovf_ctrl;
    dpdq_pkg::q_stat_t crit_stat;
    dpdq_pkg::q_stat_t ovf_stat;

    logic                      fire;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      flag_reg;
    logic                      flag_next;
    dpdq_pkg::status_t         status_reg;
    dpdq_pkg::status_t         status_next;
    logic                      event_valid_reg;
    logic                      event_valid_next;
    logic [dpdq_pkg::ID_W-1:0] selected_id_reg;
    logic [dpdq_pkg::ID_W-1:0] selected_id_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    dpdq_queue #(.DEPTH(QUEUE_DEPTH)) u_crit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crit_ctrl),
        .id    (evt_id),
        .stat  (crit_stat)
    );

    dpdq_queue #(.DEPTH(QUEUE_DEPTH)) u_ovf (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ovf_ctrl),
        .id    (evt_id),
        .stat  (ovf_stat)
    );

    always_comb
    begin
        crit_ctrl        = '0;
        ovf_ctrl         = '0;
        flag_next        = flag_reg;
        status_next      = dpdq_pkg::ST_OK;
        event_valid_next = 1'b0;
        selected_id_next = '0;
        case (dpdq_pkg::cmd_t'(command))
            dpdq_pkg::CMD_ENQ_CRIT:
            begin
                if (crit_stat.full)
                begin
                    status_next = dpdq_pkg::ST_FULL;
                end
                else if (crit_stat.dup)
                begin
                    status_next = dpdq_pkg::ST_DUP;
                end
                else
                begin
                    crit_ctrl.push = fire;
                end
            end
            dpdq_pkg::CMD_ENQ_OVF:
            begin
                if (ovf_stat.full)
                begin
                    status_next = dpdq_pkg::ST_FULL;
                end
                else if (ovf_stat.dup)
                begin
                    status_next = dpdq_pkg::ST_DUP;
                end
                else
                begin
                    ovf_ctrl.push = fire;
                end
            end
            dpdq_pkg::CMD_SELECT:
            begin
                if (poll_busy)
                begin
                    status_next = dpdq_pkg::ST_BUSY;
                end
                else if (crit_stat.empty && ovf_stat.empty)
                begin
                    flag_next   = 1'b0;
                    status_next = dpdq_pkg::ST_EMPTY;
                end
                else
                begin
                    // Overflow head reported but kept; else critical head popped.
                    if (!ovf_stat.empty)
                    begin
                        selected_id_next = ovf_stat.head;
                    end
                    else
                    begin
                        selected_id_next = crit_stat.head;
                        crit_ctrl.pop    = fire;
                    end
                    flag_next        = 1'b1;
                    event_valid_next = 1'b1;
                end
            end
            dpdq_pkg::CMD_CLEAR_OVF:
            begin
                if (ovf_stat.empty)
                begin
                    status_next = dpdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ovf_ctrl.pop = fire;
                end
            end
            default:
            begin
                status_next = dpdq_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg      <= status_next;
            event_valid_reg <= event_valid_next;
            selected_id_reg <= selected_id_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign event_valid     = event_valid_reg;
    assign selected_id     = selected_id_reg;
    assign critical_active = flag_reg;

`ifndef ASSERT_OFF
    a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> (status == dpdq_pkg::ST_OK))
        else $error("selected event reported with non-ok status");

    a_no_event_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !event_valid) |-> (selected_id == '0))
        else $error("selected_id nonzero without event");

    a_event_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> critical_active)
        else $error("selected event without critical-active flag");

    a_empty_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && command == dpdq_pkg::CMD_SELECT && !poll_busy
            && crit_stat.empty && ovf_stat.empty) |=> !critical_active)
        else $error("flag not cleared on select with both queues empty");
`endif

endmodule

FILE: rtl/core/dpdq_cell.sv
module dpdq_cell (
    input  logic                      clk,
    input  logic                      load,
    input  logic                      shift,
    input  logic [dpdq_pkg::ID_W-1:0] load_data,
    input  logic [dpdq_pkg::ID_W-1:0] shift_data,
    input  logic [dpdq_pkg::ID_W-1:0] probe_id,
    output logic [dpdq_pkg::ID_W-1:0] data,
    output logic                      match
);

    logic [dpdq_pkg::ID_W-1:0] data_reg;
    logic [dpdq_pkg::ID_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == probe_id);

endmodule

FILE: rtl/core/dpdq_queue.sv
module dpdq_queue #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dpdq_pkg::q_ctrl_t         ctrl,
    input  logic [dpdq_pkg::ID_W-1:0] id,
    output dpdq_pkg::q_stat_t         stat
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [dpdq_pkg::ID_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]          cell_match;
    logic [DEPTH-1:0]          cell_live;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [dpdq_pkg::ID_W-1:0] right_data;

            // The tail cell has no right neighbor; its content after a pop is dead.
            if (i + 1 < DEPTH)
            begin : g_mid
                assign right_data = cell_data[i+1];
            end
            else
            begin : g_tail
                assign right_data = cell_data[i];
            end

            assign cell_live[i] = (count_reg > CNT_W'(i));

            dpdq_cell u_cell (
                .clk        (clk),
                .load       (ctrl.push && (count_reg == CNT_W'(i))),
                .shift      (ctrl.pop),
                .load_data  (id),
                .shift_data (right_data),
                .probe_id   (id),
                .data       (cell_data[i]),
                .match      (cell_match[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.dup   = |(cell_match & cell_live);
    assign stat.head  = cell_data[0];

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    typedef logic [dpdq_pkg::ID_W-1:0] id_queue_t[$];

    typedef struct {
        dpdq_pkg::status_t         status;
        logic                      event_valid;
        logic [dpdq_pkg::ID_W-1:0] selected_id;
        logic                      critical_active;
    } outcome_t;

    class event_queue_scoreboard;
        id_queue_t crit_ids;
        id_queue_t ovf_ids;
        logic      crit_flag;
        outcome_t  awaited[$];
        int        errors;

        function new();
            crit_flag = 1'b0;
            errors = 0;
        endfunction

        function bit holds(id_queue_t q, logic [dpdq_pkg::ID_W-1:0] id);
            foreach (q[i])
            begin
                if (q[i] == id)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        // Apply one accepted request to the queue image and queue its outcome.
        function void note_request(dpdq_pkg::cmd_t c, logic [dpdq_pkg::ID_W-1:0] id,
                                   logic busy);
            outcome_t o;
            o.status = dpdq_pkg::ST_OK;
            o.event_valid = 1'b0;
            o.selected_id = '0;
            case (c)
                dpdq_pkg::CMD_ENQ_CRIT:
                begin
                    if (crit_ids.size() >= DEPTH)
                        o.status = dpdq_pkg::ST_FULL;
                    else if (holds(crit_ids, id))
                        o.status = dpdq_pkg::ST_DUP;
                    else
                        crit_ids.insert(crit_ids.size(), id);
                end
                dpdq_pkg::CMD_ENQ_OVF:
                begin
                    if (ovf_ids.size() >= DEPTH)
                        o.status = dpdq_pkg::ST_FULL;
                    else if (holds(ovf_ids, id))
                        o.status = dpdq_pkg::ST_DUP;
                    else
                        ovf_ids.insert(ovf_ids.size(), id);
                end
                dpdq_pkg::CMD_SELECT:
                begin
                    if (busy)
                        o.status = dpdq_pkg::ST_BUSY;
                    else if (crit_ids.size() == 0 && ovf_ids.size() == 0)
                    begin
                        crit_flag = 1'b0;
                        o.status = dpdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // ovf head is only peeked; else critical head is consumed
                        if (ovf_ids.size() != 0)
                            o.selected_id = ovf_ids[0];
                        else
                        begin
                            o.selected_id = crit_ids[0];
                            crit_ids.delete(0);
                        end
                        crit_flag = 1'b1;
                        o.event_valid = 1'b1;
                    end
                end
                default:
                begin
                    if (ovf_ids.size() == 0)
                        o.status = dpdq_pkg::ST_EMPTY;
                    else
                        ovf_ids.delete(0);
                end
            endcase
            o.critical_active = crit_flag;
            awaited.insert(awaited.size(), o);
        endfunction

        task check_result(logic [2:0] st, logic ev, logic [dpdq_pkg::ID_W-1:0] sel,
                          logic ca);
            outcome_t o;
            if (awaited.size() == 0)
            begin
                report("result with no request outstanding, status", 32'(st), 32'd0);
                return;
            end
            o = awaited[0];
            awaited.delete(0);
            if (st !== o.status)
                report("status", 32'(st), 32'(o.status));
            if (ev !== o.event_valid)
                report("event_valid", 32'(ev), 32'(o.event_valid));
            if (sel !== o.selected_id)
                report("selected_id", 32'(sel), 32'(o.selected_id));
            if (ca !== o.critical_active)
                report("critical_active", 32'(ca), 32'(o.critical_active));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    dpdq_pkg::cmd_t            command;
    logic [dpdq_pkg::ID_W-1:0] evt_id;
    logic                      poll_busy;
    logic                      out_valid;
    logic                      out_ready;
    logic [2:0]                status;
    logic                      event_valid;
    logic [dpdq_pkg::ID_W-1:0] selected_id;
    logic                      critical_active;

    event_queue_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    dual_priority_dedup_event_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .evt_id         (evt_id),
        .poll_busy      (poll_busy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .event_valid    (event_valid),
        .selected_id    (selected_id),
        .critical_active(critical_active)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, event_valid, selected_id, critical_active);
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_request(dpdq_pkg::cmd_t c, logic [dpdq_pkg::ID_W-1:0] id,
                                logic busy);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        command <= c;
        evt_id <= id;
        poll_busy <= busy;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(c, id, busy);
        @(negedge clk);
    endtask

    task automatic run_phase(int n_items, int idle_pct, int stall_pct);
        int                        roll;
        int                        enq_bias;
        dpdq_pkg::cmd_t            c;
        logic [dpdq_pkg::ID_W-1:0] id;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        enq_bias = 50;
        for (int n = 0; n < n_items; n++)
        begin
            // swing between filling and draining so both queues hit full and empty
            if (n % 32 == 0)
                enq_bias = $urandom_range(20, 90);
            roll = $urandom_range(99);
            if (roll < enq_bias)
                c = $urandom_range(1) ? dpdq_pkg::CMD_ENQ_CRIT : dpdq_pkg::CMD_ENQ_OVF;
            else if ($urandom_range(9) < 6)
                c = dpdq_pkg::CMD_SELECT;
            else
                c = dpdq_pkg::CMD_CLEAR_OVF;
            roll = $urandom_range(9);
            if (roll < 6)
                id = dpdq_pkg::ID_W'($urandom_range(23));
            else if (roll == 6)
                id = 16'hFFFF - dpdq_pkg::ID_W'($urandom_range(3));
            else
                id = dpdq_pkg::ID_W'($urandom);
            send_request(c, id, $urandom_range(3) == 0);
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("FAIL dual_priority_dedup_event_queue_unit");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = dpdq_pkg::CMD_ENQ_CRIT;
        evt_id = '0;
        poll_busy = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(dpdq_pkg::CMD_SELECT, 16'h0000, 1'b1);
        send_request(dpdq_pkg::CMD_SELECT, 16'hFFFF, 1'b0);
        send_request(dpdq_pkg::CMD_CLEAR_OVF, 16'h0000, 1'b0);
        send_request(dpdq_pkg::CMD_ENQ_CRIT, 16'h0000, 1'b0);
        send_request(dpdq_pkg::CMD_ENQ_CRIT, 16'hFFFF, 1'b1);
        send_request(dpdq_pkg::CMD_ENQ_CRIT, 16'hFFFF, 1'b0);
        // same ID in the other queue is not a duplicate
        send_request(dpdq_pkg::CMD_ENQ_OVF, 16'hFFFF, 1'b0);
        send_request(dpdq_pkg::CMD_SELECT, 16'h0000, 1'b0);
        send_request(dpdq_pkg::CMD_CLEAR_OVF, 16'h1234, 1'b1);
        send_request(dpdq_pkg::CMD_CLEAR_OVF, 16'h0000, 1'b0);
        send_request(dpdq_pkg::CMD_SELECT, 16'h0000, 1'b0);
        for (int k = 0; k < DEPTH - 1; k++)
            send_request(dpdq_pkg::CMD_ENQ_CRIT, 16'hA5A5 ^ dpdq_pkg::ID_W'(k), 1'b0);
        // full wins over duplicate
        send_request(dpdq_pkg::CMD_ENQ_CRIT, 16'hFFFF, 1'b0);

        run_phase(350, 0, 0);
        run_phase(350, 70, 0);
        run_phase(350, 0, 70);
        run_phase(350, 17, 17);
        in_valid <= 1'b0;

        for (int w = 0; w < 20000 && sb.awaited.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.report("requests left without a result, count", 32'(sb.awaited.size()),
                      32'd0);
        if (sb.errors == 0)
            $display("PASS dual_priority_dedup_event_queue_unit");
        else
            $display("FAIL dual_priority_dedup_event_queue_unit");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dpdq_pkg.sv
rtl/core/dpdq_cell.sv
rtl/core/dpdq_queue.sv
rtl/core/dual_priority_dedup_event_queue_unit.sv
tb/tb_top.sv
